[rtl/core/rat_pkg.sv]
// Shared types and constants for the rational add/multiply/reduce pipeline.
`default_nettype none

package rat_pkg;

	localparam int NUM_OUT_BITS = 33;
	localparam int DEN_OUT_BITS = 32;

	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_MUL = 1'b1;

	// Sign and special-case flags that ride along with the magnitudes.
	typedef struct packed {
		logic n_neg;
		logic d_neg;
		logic zero_num;
	} side_t;

endpackage

`default_nettype wire

[rtl/core/rat_front.sv]
// Front end: cross products, then the sum, magnitudes and sign flags.
`default_nettype none

module rat_front #(
	parameter int OB = 16,
	parameter int VW = 33
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_v,
	input  logic                  kind,
	input  logic signed [OB-1:0]  a_num,
	input  logic signed [OB-1:0]  a_den,
	input  logic signed [OB-1:0]  b_num,
	input  logic signed [OB-1:0]  b_den,
	output logic                  v_s2,
	output logic [VW-1:0]         nmag_s2,
	output logic [VW-1:0]         dmag_s2,
	output rat_pkg::side_t        side_s2
);
	import rat_pkg::*;

	localparam int SW = 2 * OB + 1;

	logic signed [OB-1:0]   bsel;
	logic signed [2*OB-1:0] p0_w, p1_w, pd_w;
	logic signed [2*OB-1:0] p0_s1, p1_s1, pd_s1;
	logic                   kind_s1, v_s1;
	logic signed [SW-1:0]   sum_w;
	logic [VW-1:0]          num_w, den_w;
	side_t                  side_w;

	assign bsel = (kind == KIND_MUL) ? b_num : b_den;
	assign p0_w = a_num * bsel;
	assign p1_w = b_num * a_den;
	assign pd_w = a_den * b_den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1   <= p0_w;
			p1_s1   <= p1_w;
			pd_s1   <= pd_w;
			kind_s1 <= kind;
		end
	end

	// Beyond the natural width the sum wraps to the internal word, as required.
	assign sum_w = (kind_s1 == KIND_MUL) ? SW'(p0_s1) : SW'(p0_s1) + SW'(p1_s1);
	assign num_w = sum_w[VW-1:0];
	assign den_w = VW'(pd_s1);

	always_comb begin
		side_w.n_neg    = num_w[VW-1];
		side_w.d_neg    = den_w[VW-1];
		side_w.zero_num = (num_w == '0) && (den_w != '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s2 <= num_w[VW-1] ? ('0 - num_w) : num_w;
			dmag_s2 <= den_w[VW-1] ? ('0 - den_w) : den_w;
			side_s2 <= side_w;
		end
	end

endmodule

`default_nettype wire

[rtl/core/rat_gcd.sv]
// Binary gcd unrolled into one register stage per step, then the divisor stage.
`default_nettype none

module rat_gcd #(
	parameter int VW = 33
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  logic [VW-1:0]   nmag,
	input  logic [VW-1:0]   dmag,
	input  rat_pkg::side_t  side,
	output logic            v_sg,
	output logic [VW-1:0]   g_sg,
	output logic [VW-1:0]   nmag_sg,
	output logic [VW-1:0]   dmag_sg,
	output rat_pkg::side_t  side_sg
);
	import rat_pkg::*;

	// Each step shortens one operand by at least a bit until one operand is zero.
	localparam int GS = 2 * VW;
	localparam int KW = $clog2(VW + 1);

	logic [VW-1:0] x_c [0:GS-1];
	logic [VW-1:0] y_c [0:GS-1];
	logic [KW-1:0] k_c [0:GS-1];
	logic          v_c [0:GS-1];
	logic [VW-1:0] n_c [0:GS-1];
	logic [VW-1:0] d_c [0:GS-1];
	side_t         sd_c [0:GS-1];

	logic [VW-1:0] x_s [1:GS];
	logic [VW-1:0] y_s [1:GS];
	logic [KW-1:0] k_s [1:GS];
	logic          v_s [1:GS];
	logic [VW-1:0] n_s [1:GS];
	logic [VW-1:0] d_s [1:GS];
	side_t         sd_s [1:GS];

	logic [VW-1:0] g_w;

	assign x_c[0]  = nmag;
	assign y_c[0]  = dmag;
	assign k_c[0]  = '0;
	assign v_c[0]  = in_v;
	assign n_c[0]  = nmag;
	assign d_c[0]  = dmag;
	assign sd_c[0] = side;

	for (genvar i = 0; i < GS; i++) begin : g_step
		logic [VW-1:0] xn, yn;
		logic [KW-1:0] kn;

		if (i > 0) begin : g_src
			assign x_c[i]  = x_s[i];
			assign y_c[i]  = y_s[i];
			assign k_c[i]  = k_s[i];
			assign v_c[i]  = v_s[i];
			assign n_c[i]  = n_s[i];
			assign d_c[i]  = d_s[i];
			assign sd_c[i] = sd_s[i];
		end

		always_comb begin
			xn = x_c[i];
			yn = y_c[i];
			kn = k_c[i];
			if ((x_c[i] == '0) || (y_c[i] == '0)) begin
				xn = x_c[i];
			end else if (!x_c[i][0] && !y_c[i][0]) begin
				xn = x_c[i] >> 1;
				yn = y_c[i] >> 1;
				kn = k_c[i] + 1'b1;
			end else if (!x_c[i][0]) begin
				xn = x_c[i] >> 1;
			end else if (!y_c[i][0]) begin
				yn = y_c[i] >> 1;
			end else if (x_c[i] >= y_c[i]) begin
				xn = (x_c[i] - y_c[i]) >> 1;
			end else begin
				yn = (y_c[i] - x_c[i]) >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_c[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1]  <= xn;
				y_s[i+1]  <= yn;
				k_s[i+1]  <= kn;
				n_s[i+1]  <= n_c[i];
				d_s[i+1]  <= d_c[i];
				sd_s[i+1] <= sd_c[i];
			end
		end
	end

	// One operand is zero by now; the other holds the odd part of the gcd.
	// A zero gcd divides by one so both parts pass unchanged.
	assign g_w = (x_s[GS] | y_s[GS]) << k_s[GS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sg <= 1'b0;
		end else if (en) begin
			v_sg <= v_s[GS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_sg    <= (g_w == '0) ? VW'(1) : g_w;
			nmag_sg <= n_s[GS];
			dmag_sg <= d_s[GS];
			side_sg <= sd_s[GS];
		end
	end

endmodule

`default_nettype wire

[rtl/core/rat_div.sv]
// Two restoring dividers in lockstep, one quotient bit per register stage.
`default_nettype none

module rat_div #(
	parameter int VW = 33
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  logic [VW-1:0]   g,
	input  logic [VW-1:0]   nmag,
	input  logic [VW-1:0]   dmag,
	input  rat_pkg::side_t  side,
	output logic            v_sd,
	output logic [VW-1:0]   qn_sd,
	output logic [VW-1:0]   qd_sd,
	output rat_pkg::side_t  side_sd
);
	import rat_pkg::*;

	logic [VW-1:0] g_c  [0:VW-1];
	logic [VW-1:0] rn_c [0:VW-1];
	logic [VW-1:0] qn_c [0:VW-1];
	logic [VW-1:0] rd_c [0:VW-1];
	logic [VW-1:0] qd_c [0:VW-1];
	logic          v_c  [0:VW-1];
	side_t         sd_c [0:VW-1];

	logic [VW-1:0] g_s  [1:VW];
	logic [VW-1:0] rn_s [1:VW];
	logic [VW-1:0] qn_s [1:VW];
	logic [VW-1:0] rd_s [1:VW];
	logic [VW-1:0] qd_s [1:VW];
	logic          v_s  [1:VW];
	side_t         sd_s [1:VW];

	assign g_c[0]  = g;
	assign rn_c[0] = '0;
	assign qn_c[0] = nmag;
	assign rd_c[0] = '0;
	assign qd_c[0] = dmag;
	assign v_c[0]  = in_v;
	assign sd_c[0] = side;

	for (genvar i = 0; i < VW; i++) begin : g_bit
		logic [VW:0]   tn, td;
		logic          gen, ged;
		logic [VW-1:0] rnn, rdn;

		if (i > 0) begin : g_src
			assign g_c[i]  = g_s[i];
			assign rn_c[i] = rn_s[i];
			assign qn_c[i] = qn_s[i];
			assign rd_c[i] = rd_s[i];
			assign qd_c[i] = qd_s[i];
			assign v_c[i]  = v_s[i];
			assign sd_c[i] = sd_s[i];
		end

		// The dividend shifts out at the top while quotient bits shift in below.
		assign tn  = {rn_c[i], qn_c[i][VW-1]};
		assign td  = {rd_c[i], qd_c[i][VW-1]};
		assign gen = tn >= {1'b0, g_c[i]};
		assign ged = td >= {1'b0, g_c[i]};
		assign rnn = gen ? VW'(tn - {1'b0, g_c[i]}) : tn[VW-1:0];
		assign rdn = ged ? VW'(td - {1'b0, g_c[i]}) : td[VW-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_c[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				g_s[i+1]  <= g_c[i];
				rn_s[i+1] <= rnn;
				rd_s[i+1] <= rdn;
				qn_s[i+1] <= {qn_c[i][VW-2:0], gen};
				qd_s[i+1] <= {qd_c[i][VW-2:0], ged};
				sd_s[i+1] <= sd_c[i];
			end
		end
	end

	assign v_sd    = v_s[VW];
	assign qn_sd   = qn_s[VW];
	assign qd_sd   = qd_s[VW];
	assign side_sd = sd_s[VW];

endmodule

`default_nettype wire

[rtl/core/rational_add_mul_reduce.sv]
// Top level: fraction add/multiply with gcd reduction, fully pipelined.
//
// Input channel (in_valid/in_ready) takes kind, a_num/a_den, b_num/b_den; kind
// selects add or multiply. Output channel (out_valid/out_ready) returns
// res_num/res_den reduced by the gcd of their magnitudes, signs as computed.
// A zero numerator with a nonzero denominator gives 0/1.
//
// With W = 2*OPERAND_BITS+1 (at most 64) the pipeline holds two front stages,
// 2*W gcd steps, one divisor stage, W divider stages and the output register.
// The gcd steps and the divider bits make up most of that depth.
// One beat can enter every cycle while in_ready is high.
//
// Reset clears all valid bits; the pipeline is empty afterwards.
// When out_ready is low the output register holds its beat and one more beat
// drops into a skid register; the whole pipeline then freezes and in_ready
// falls until the skid register drains. Nothing is lost or repeated.
`default_nettype none

module rational_add_mul_reduce #(
	parameter int OPERAND_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   kind,
	input  logic signed [OPERAND_BITS-1:0]         a_num,
	input  logic signed [OPERAND_BITS-1:0]         a_den,
	input  logic signed [OPERAND_BITS-1:0]         b_num,
	input  logic signed [OPERAND_BITS-1:0]         b_den,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [rat_pkg::NUM_OUT_BITS-1:0] res_num,
	output logic signed [rat_pkg::DEN_OUT_BITS-1:0] res_den
);
	import rat_pkg::*;

	localparam int VW = (2 * OPERAND_BITS + 1 > 64) ? 64 : 2 * OPERAND_BITS + 1;

	logic          en;
	logic          f_v;
	logic [VW-1:0] f_nmag, f_dmag;
	side_t         f_side;
	logic          g_v;
	logic [VW-1:0] g_g, g_nmag, g_dmag;
	side_t         g_side;
	logic          d_v;
	logic [VW-1:0] d_qn, d_qd;
	side_t         d_side;

	logic [VW-1:0] nval, dval;
	logic [63:0]   n64, d64;
	logic [NUM_OUT_BITS-1:0] cn;
	logic [DEN_OUT_BITS-1:0] cd;
	logic          leave;

	logic                    out_v_q, skid_v_q;
	logic [NUM_OUT_BITS-1:0] out_num_q, skid_num_q;
	logic [DEN_OUT_BITS-1:0] out_den_q, skid_den_q;

	assign en       = !skid_v_q;
	assign in_ready = en;

	rat_front #(.OB(OPERAND_BITS), .VW(VW)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (in_valid),
		.kind    (kind),
		.a_num   (a_num),
		.a_den   (a_den),
		.b_num   (b_num),
		.b_den   (b_den),
		.v_s2    (f_v),
		.nmag_s2 (f_nmag),
		.dmag_s2 (f_dmag),
		.side_s2 (f_side)
	);

	rat_gcd #(.VW(VW)) u_gcd (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (f_v),
		.nmag    (f_nmag),
		.dmag    (f_dmag),
		.side    (f_side),
		.v_sg    (g_v),
		.g_sg    (g_g),
		.nmag_sg (g_nmag),
		.dmag_sg (g_dmag),
		.side_sg (g_side)
	);

	rat_div #(.VW(VW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (g_v),
		.g       (g_g),
		.nmag    (g_nmag),
		.dmag    (g_dmag),
		.side    (g_side),
		.v_sd    (d_v),
		.qn_sd   (d_qn),
		.qd_sd   (d_qd),
		.side_sd (d_side)
	);

	// Restore signs, then sign-extend or truncate to the result fields.
	assign nval = d_side.n_neg ? ('0 - d_qn) : d_qn;
	assign dval = d_side.d_neg ? ('0 - d_qd) : d_qd;
	assign n64  = 64'(signed'(nval));
	assign d64  = 64'(signed'(dval));
	assign cn   = n64[NUM_OUT_BITS-1:0];
	assign cd   = d_side.zero_num ? DEN_OUT_BITS'(1) : d64[DEN_OUT_BITS-1:0];

	assign leave = en && d_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			out_v_q  <= skid_v_q || leave;
			skid_v_q <= 1'b0;
		end else if (leave) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_num_q <= skid_num_q;
				out_den_q <= skid_den_q;
			end else if (leave) begin
				out_num_q <= cn;
				out_den_q <= cd;
			end
		end else if (leave) begin
			skid_num_q <= cn;
			skid_den_q <= cd;
		end
	end

	assign out_valid = out_v_q;
	assign res_num   = out_num_q;
	assign res_den   = out_den_q;

endmodule

`default_nettype wire

[rtl/core/rat_checker.sv]
// Port-level checker for the rational pipeline and its bind to the top level.
`default_nettype none

module rat_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_ready,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [rat_pkg::NUM_OUT_BITS-1:0]  res_num,
	input  logic [rat_pkg::DEN_OUT_BITS-1:0]  res_den
);
	import rat_pkg::*;

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(res_num) && $stable(res_den))
		else $error("result payload changed while stalled");

	// The input side only backs up behind a result that is waiting.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input blocked with no result pending");

	// A zero numerator over a nonzero denominator is always shown as 0/1.
	a_zero_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (res_num == '0) && (res_den != '0) |-> (res_den == DEN_OUT_BITS'(1)))
		else $error("zero result not normalized to 0/1");

endmodule

bind rational_add_mul_reduce rat_checker u_rat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.res_num   (res_num),
	.res_den   (res_den)
);

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the rational add/multiply/reduce pipeline.
`default_nettype none

class frac_scoreboard;
	logic signed [32:0] exp_num_q[$];
	logic signed [31:0] exp_den_q[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	// Works out the reduced fraction for one accepted input beat.
	function void note_operands(logic kind, logic signed [15:0] an, logic signed [15:0] ad,
			logic signed [15:0] bn, logic signed [15:0] bd);
		longint num, den, x, y, r, g;
		if (kind == rat_pkg::KIND_ADD)
			num = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
		else
			num = longint'(an) * longint'(bn);
		den = longint'(ad) * longint'(bd);
		if (num == 0 && den != 0) begin
			den = 1;
		end else begin
			x = (num < 0) ? -num : num;
			y = (den < 0) ? -den : den;
			while (y != 0) begin
				r = x % y;
				x = y;
				y = r;
			end
			g = x;
			if (g != 0) begin
				num = num / g;
				den = den / g;
			end
		end
		exp_num_q.push_back(num[32:0]);
		exp_den_q.push_back(den[31:0]);
	endfunction

	function void check_result(logic signed [32:0] num, logic signed [31:0] den);
		if (exp_num_q.size() == 0) begin
			$display("%0t: expected no result, actual %0d/%0d", $time, num, den);
			errors++;
			return;
		end
		if (num !== exp_num_q[0]) begin
			$display("%0t: res_num expected %0d actual %0d", $time, exp_num_q[0], num);
			errors++;
		end
		if (den !== exp_den_q[0]) begin
			$display("%0t: res_den expected %0d actual %0d", $time, exp_den_q[0], den);
			errors++;
		end
		void'(exp_num_q.pop_front());
		void'(exp_den_q.pop_front());
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = 1'b0;
	logic signed [15:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [32:0] res_num;
	logic signed [31:0] res_den;
	logic stim_done = 1'b0;
	int beat_cnt = 0;

	frac_scoreboard sb = new();

	rational_add_mul_reduce u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_ready(out_ready), .res_num(res_num), .res_den(res_den)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Idles at random on either side, but not in a quiet stretch of beats 400 to 699.
	function automatic logic idle_now();
		if (beat_cnt >= 400 && beat_cnt < 700)
			return 1'b0;
		return $urandom_range(99) < 18;
	endfunction

	function automatic logic [15:0] rand_operand();
		case ($urandom_range(5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($signed($urandom_range(10)) - 5);
			3: return 16'($urandom_range(255));
			default: return 16'($urandom);
		endcase
	endfunction

	// Valid drops only while idling, so back-to-back beats keep it high.
	task automatic send_operands(logic k, logic [15:0] an, logic [15:0] ad,
			logic [15:0] bn, logic [15:0] bd);
		while (idle_now()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		do @(posedge clk); while (!in_ready);
		sb.note_operands(k, an, ad, bn, bd);
		beat_cnt++;
		@(negedge clk);
	endtask

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(res_num, res_den);

	always @(negedge clk)
		out_ready <= stim_done ? 1'b1 : !idle_now();

	initial begin
		int k;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (k = 0; k < 2; k++) begin
			send_operands(1'(k), 16'sd1, 16'sd2, 16'sd1, 16'sd3);
			send_operands(1'(k), 16'sd0, 16'sd5, 16'sd0, 16'sd7);
			send_operands(1'(k), 16'sd0, 16'sd0, 16'sd0, 16'sd0);
			send_operands(1'(k), 16'sd3, 16'sd0, 16'sd4, 16'sd0);
			send_operands(1'(k), -16'sd3, 16'sd0, 16'sd4, 16'sd0);
			send_operands(1'(k), 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
			send_operands(1'(k), 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
			send_operands(1'(k), 16'sh8000, 16'sd1, 16'sh8000, 16'sd1);
			send_operands(1'(k), 16'sd5, -16'sd4, 16'sd7, 16'sd1);
			send_operands(1'(k), 16'sh7fff, 16'sh7fff, -16'sd1, 16'sh7fff);
			send_operands(1'(k), 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		end
		repeat (1500)
			send_operands(1'($urandom_range(1)), rand_operand(), rand_operand(),
				rand_operand(), rand_operand());
		in_valid <= 1'b0;
		stim_done <= 1'b1;
		while (sb.exp_num_q.size() != 0) @(negedge clk);
		repeat (120) @(negedge clk);
		if (sb.errors == 0 && sb.exp_num_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

`default_nettype wire
